>>> hdl/nnt_pkg.sv
// Shared constants, state codes and the command/status structs of the tour builder.
// No dependencies; imported by every module of the block.
package nnt_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_BITS_DEF = 16;
   localparam int PX_BITS        = 16;
   localparam int CITY_BITS      = 6;
   localparam int REQ_DATA_BITS  = 32;
   localparam int RSP_DATA_BITS  = 8;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_EMIT  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
      logic issue;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic tour_last;
      logic issue_last;
      logic result_done;
   } status_type;

endpackage

>>> hdl/nnt_ctrl.sv
// Sequencer of the tour builder: load points, emit an index, scan, drain.
// Depends on nnt_pkg for state codes and the command/status structs.
module nnt_ctrl
   import nnt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output word is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.tour_last ? ST_LOAD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.result_done) begin
               state_in = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/nnt_datapath.sv
// Point store, visited flags, distance pipeline, best tracker and output word register.
// Depends on nnt_pkg; driven by the commands of nnt_ctrl.
module nnt_datapath
   import nnt_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic [PX_BITS-1:0]   px,
   input  logic [PX_BITS-1:0]   py,
   input  logic                 rsp_ready,
   output status_type           status,
   output logic                 rsp_valid,
   output logic [CITY_BITS-1:0] rsp_city,
   output logic                 rsp_end,
   output logic                 rsp_ovf
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int IN_W   = (COORD_BITS > PX_BITS) ? COORD_BITS : PX_BITS;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int DIST_W = 2 * COORD_BITS + 1;

   // point store
   logic [COORD_BITS-1:0] xmem [MAX_POINTS];
   logic [COORD_BITS-1:0] ymem [MAX_POINTS];

   logic [IN_W-1:0]       px_ext, py_ext;
   logic [COORD_BITS-1:0] wr_x, wr_y;
   logic                  has_room;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [MAX_POINTS-1:0] visited_ff, visited_in;

   logic [COORD_BITS-1:0] cur_x_ff, cur_y_ff;
   logic [DIST_W-1:0]     best_dist_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [COORD_BITS-1:0] best_x_ff, best_y_ff;

   // pipeline: read, difference, square, compare
   logic                  p1_valid_ff, p1_last_ff, p1_skip_ff;
   logic [IDX_W-1:0]      p1_idx_ff;
   logic [COORD_BITS-1:0] p1_x_ff, p1_y_ff;

   logic                  p2_valid_ff, p2_last_ff, p2_skip_ff;
   logic [IDX_W-1:0]      p2_idx_ff;
   logic [COORD_BITS-1:0] p2_x_ff, p2_y_ff, p2_dx_ff, p2_dy_ff;

   logic                  p3_valid_ff, p3_last_ff, p3_skip_ff;
   logic [IDX_W-1:0]      p3_idx_ff;
   logic [COORD_BITS-1:0] p3_x_ff, p3_y_ff;
   logic [SQ_W-1:0]       p3_dxx_ff, p3_dyy_ff;

   logic [DIST_W-1:0]     dist_sum;
   logic                  take_best;

   logic                  out_valid_ff;
   logic [CITY_BITS-1:0]  out_city_ff;
   logic                  out_end_ff, out_ovf_ff;

   assign px_ext   = IN_W'(px);
   assign py_ext   = IN_W'(py);
   assign wr_x     = px_ext[COORD_BITS-1:0];
   assign wr_y     = py_ext[COORD_BITS-1:0];
   assign has_room = (count_ff != CNT_W'(MAX_POINTS));

   assign status.out_free    = !out_valid_ff || rsp_ready;
   assign status.tour_last   = (step_ff + CNT_W'(1)) == count_ff;
   assign status.issue_last  = (scan_ff + CNT_W'(1)) == count_ff;
   assign status.result_done = p3_valid_ff && p3_last_ff;

   // control registers
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      step_in    = step_ff;
      scan_in    = scan_ff;
      visited_in = visited_ff;
      if (cmd.load) begin
         if (has_room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.issue) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      if (cmd.emit) begin
         scan_in = '0;
         if (status.tour_last) begin
            // tour done: start a fresh set
            count_in   = '0;
            dropped_in = 1'b0;
            step_in    = '0;
            visited_in = '0;
         end else begin
            step_in                 = step_ff + CNT_W'(1);
            visited_in[best_idx_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         step_ff      <= '0;
         scan_ff      <= '0;
         visited_ff   <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
         step_ff     <= step_in;
         scan_ff     <= scan_in;
         visited_ff  <= visited_in;
         p1_valid_ff <= cmd.issue;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         xmem[count_ff[IDX_W-1:0]] <= wr_x;
         ymem[count_ff[IDX_W-1:0]] <= wr_y;
      end
      p1_x_ff <= xmem[scan_ff[IDX_W-1:0]];
      p1_y_ff <= ymem[scan_ff[IDX_W-1:0]];
   end

   // distance pipeline payload
   always_ff @(posedge clock) begin
      p1_idx_ff  <= scan_ff[IDX_W-1:0];
      p1_last_ff <= status.issue_last;
      p1_skip_ff <= visited_ff[scan_ff[IDX_W-1:0]];

      p2_idx_ff  <= p1_idx_ff;
      p2_last_ff <= p1_last_ff;
      p2_skip_ff <= p1_skip_ff;
      p2_x_ff    <= p1_x_ff;
      p2_y_ff    <= p1_y_ff;
      p2_dx_ff   <= (p1_x_ff >= cur_x_ff) ? p1_x_ff - cur_x_ff : cur_x_ff - p1_x_ff;
      p2_dy_ff   <= (p1_y_ff >= cur_y_ff) ? p1_y_ff - cur_y_ff : cur_y_ff - p1_y_ff;

      p3_idx_ff  <= p2_idx_ff;
      p3_last_ff <= p2_last_ff;
      p3_skip_ff <= p2_skip_ff;
      p3_x_ff    <= p2_x_ff;
      p3_y_ff    <= p2_y_ff;
      p3_dxx_ff  <= SQ_W'(p2_dx_ff) * SQ_W'(p2_dx_ff);
      p3_dyy_ff  <= SQ_W'(p2_dy_ff) * SQ_W'(p2_dy_ff);
   end

   assign dist_sum  = DIST_W'(p3_dxx_ff) + DIST_W'(p3_dyy_ff);
   assign take_best = p3_valid_ff && !p3_skip_ff && (dist_sum < best_dist_ff);

   // best candidate and current point; strict compare keeps the lowest index on a tie
   always_ff @(posedge clock) begin
      if (cmd.load && has_room && (count_ff == '0)) begin
         cur_x_ff    <= wr_x;
         cur_y_ff    <= wr_y;
         best_x_ff   <= wr_x;
         best_y_ff   <= wr_y;
         best_idx_ff <= '0;
      end else if (take_best) begin
         best_x_ff   <= p3_x_ff;
         best_y_ff   <= p3_y_ff;
         best_idx_ff <= p3_idx_ff;
      end
      if (cmd.emit) begin
         cur_x_ff     <= best_x_ff;
         cur_y_ff     <= best_y_ff;
         best_dist_ff <= '1;
      end else if (take_best) begin
         best_dist_ff <= dist_sum;
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_city_ff <= CITY_BITS'(best_idx_ff);
         out_end_ff  <= status.tour_last;
         out_ovf_ff  <= dropped_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_city  = out_city_ff;
   assign rsp_end   = out_end_ff;
   assign rsp_ovf   = out_ovf_ff;

endmodule

>>> hdl/nearest_neighbor_tour.sv
// Nearest-neighbor tour builder. Points load at one word per cycle while the builder is loading;
// the word with tlast starts the tour. The first index goes to the output word once that word is
// free. Each later index needs a scan that issues one store read per point through the 3 pipeline
// stages (read, difference, square) and the compare, then an emit once the output word is free.
// No input is taken while the tour runs. Synchronous active-high reset clears the set, visited
// flags and output word at once; no clearing pass follows.
module nearest_neighbor_tour
   import nnt_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)(
   input  logic                     clock,
   input  logic                     reset,
   // input channel: one point per word
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [15:0] px, [31:16] py
   input  logic                     req_tlast,  // final_point
   // result channel: one tour index per word
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // [5:0] city, [7:6] zero
   output logic                     rsp_tlast,  // tour_end
   output logic                     rsp_tuser   // overflow
);

   cmd_type              cmd;
   status_type           status;
   logic [CITY_BITS-1:0] city;

   // sequencer: loading, scanning and emitting never overlap
   nnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   // store, distance pipeline and output register
   nnt_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .px        (req_tdata[PX_BITS-1:0]),
      .py        (req_tdata[2*PX_BITS-1:PX_BITS]),
      .rsp_ready (rsp_tready),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_city  (city),
      .rsp_end   (rsp_tlast),
      .rsp_ovf   (rsp_tuser)
   );

   // pad the index up to a whole byte
   assign rsp_tdata = RSP_DATA_BITS'(city);

endmodule

>>> hdl/nnt_checker.sv
// Port-level checks of the tour builder, bound onto the top level.
// Depends on nnt_pkg for channel widths.
module nnt_checker
   import nnt_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     req_tlast,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast,
   input logic                     rsp_tuser
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable({rsp_tdata, rsp_tlast, rsp_tuser}))
      else $error("result word changed while stalled");

   // taking the final point drops the input ready
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after the final point");

   // city index never exceeds six bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_BITS-1:CITY_BITS] == '0)
      else $error("padding bits of result word set");

   // reset empties the output and opens the input
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind nearest_neighbor_tour nnt_checker u_checker (.*);
